@@ rtl/line_window_min_filter_defines.svh @@
// Assertion macros shared by the line window minimum filter RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef LINE_WINDOW_MIN_FILTER_DEFINES_SVH
`define LINE_WINDOW_MIN_FILTER_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define LWMF_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define LWMF_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ rtl/lwmf_pkg.sv @@
// Shared widths, constants and types of the line window minimum filter.
// Depends on nothing; used by every other file of the block but the defines header.
`timescale 1ns / 1ps

package lwmf_pkg;

   // Payload and register widths.
   localparam int SAMPLE_W    = 16;
   localparam int RADIUS_W    = 5;

   // Window and line limits.
   localparam int MAX_RADIUS  = 31;
   localparam int LINE_MAX    = 4096;
   localparam int POS_W       = $clog2(LINE_MAX);
   localparam int CHAIN_DEPTH = 2 * MAX_RADIUS + 1;
   localparam int TAP_W       = $clog2(CHAIN_DEPTH);

   localparam logic [RADIUS_W-1:0] DEFAULT_RADIUS = RADIUS_W'(10);
   localparam logic [POS_W-1:0]    POS_LAST       = POS_W'(LINE_MAX - 1);

   // Neutral value of the minimum: larger than or equal to every sample.
   localparam logic [SAMPLE_W-1:0] SAMPLE_INF = '1;

   // Control that the sequencer hands to the row of cells.
   typedef struct packed {
      logic             shift;
      logic             line_start;
      logic             flush;
      logic [TAP_W-1:0] tap;
   } chain_ctrl_type;

endpackage

@@ rtl/lwmf_if.sv @@
// Valid/ready channel interfaces of the line window minimum filter.
// Depends on lwmf_pkg for the payload widths.
`timescale 1ns / 1ps

// Input channel: one sample of the line per item.
interface lwmf_req_if;
   logic                          valid;
   logic                          ready;
   logic [lwmf_pkg::SAMPLE_W-1:0] sample;
   logic                          last_in_line;

   modport source (output valid, output sample, output last_in_line, input ready);
   modport sink   (input valid, input sample, input last_in_line, output ready);
endinterface

// Result channel: one window minimum per item.
interface lwmf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lwmf_pkg::SAMPLE_W-1:0] min_value;
   logic                          last_of_line;

   modport source (output valid, output min_value, output last_of_line, input ready);
   modport sink   (input valid, input min_value, input last_of_line, output ready);
endinterface

@@ rtl/lwmf_cell.sv @@
// One cell of the running-minimum row: holds the minimum of the last k+1 samples.
// Depends on lwmf_pkg for widths and the control struct.
`timescale 1ns / 1ps

module lwmf_cell (
   input  logic                          clock,
   input  lwmf_pkg::chain_ctrl_type      ctl,
   input  logic [lwmf_pkg::SAMPLE_W-1:0] sample,
   input  logic [lwmf_pkg::SAMPLE_W-1:0] nbr_value,
   output logic [lwmf_pkg::SAMPLE_W-1:0] value_out,
   output logic [lwmf_pkg::SAMPLE_W-1:0] value_next
);

   logic [lwmf_pkg::SAMPLE_W-1:0] value_ff;
   logic [lwmf_pkg::SAMPLE_W-1:0] value_in;
   logic [lwmf_pkg::SAMPLE_W-1:0] older_min;

   // At the start of a line the neighbor holds the previous line, so it is ignored.
   assign older_min = ctl.line_start ? lwmf_pkg::SAMPLE_INF : nbr_value;

   // A new sample extends the neighbor's window by one position.
   always_comb begin
      value_in = value_ff;
      if (ctl.shift) begin
         value_in = (sample < older_min) ? sample : older_min;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out  = value_ff;
   assign value_next = value_in;

endmodule

@@ rtl/lwmf_chain.sv @@
// Row of running-minimum cells and the tap select that picks a window length.
// Depends on lwmf_pkg and lwmf_cell.
`timescale 1ns / 1ps

module lwmf_chain (
   input  logic                          clock,
   input  lwmf_pkg::chain_ctrl_type      ctl,
   input  logic [lwmf_pkg::SAMPLE_W-1:0] sample,
   output logic [lwmf_pkg::SAMPLE_W-1:0] tap_value
);

   logic [lwmf_pkg::SAMPLE_W-1:0] cell_value [lwmf_pkg::CHAIN_DEPTH];
   logic [lwmf_pkg::SAMPLE_W-1:0] cell_next  [lwmf_pkg::CHAIN_DEPTH];

   // Cell k takes its older window from cell k-1; the first cell has none.
   for (genvar k = 0; k < lwmf_pkg::CHAIN_DEPTH; k++) begin : g_cell
      logic [lwmf_pkg::SAMPLE_W-1:0] nbr;

      if (k == 0) begin : g_head
         assign nbr = lwmf_pkg::SAMPLE_INF;
      end else begin : g_body
         assign nbr = cell_value[k-1];
      end

      lwmf_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .sample     (sample),
         .nbr_value  (nbr),
         .value_out  (cell_value[k]),
         .value_next (cell_next[k])
      );
   end

   // The tap index is the window length minus one.
   always_comb begin
      tap_value = lwmf_pkg::SAMPLE_INF;
      if (ctl.tap < lwmf_pkg::TAP_W'(lwmf_pkg::CHAIN_DEPTH)) begin
         tap_value = cell_next[ctl.tap];
      end
   end

endmodule

@@ rtl/lwmf_ctrl.sv @@
// Sequencer of the filter: line position, radius register, end-of-line flush
// and the result register. Depends on lwmf_pkg and the channel interfaces.
`timescale 1ns / 1ps

module lwmf_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   lwmf_req_if.sink                      req_bus,
   lwmf_rsp_if.source                    rsp_bus,
   input  logic                          csr_write_enable,
   input  logic [lwmf_pkg::RADIUS_W-1:0] csr_write_data,
   input  logic [lwmf_pkg::SAMPLE_W-1:0] tap_value,
   output lwmf_pkg::chain_ctrl_type      chain_ctl
);

   typedef enum logic [1:0] {
      ST_RUN   = 2'b01,
      ST_FLUSH = 2'b10
   } state_type;

   state_type                     state_ff, state_in;
   logic [lwmf_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic [lwmf_pkg::POS_W-1:0]    target_ff, target_in;
   logic [lwmf_pkg::POS_W-1:0]    end_ff, end_in;
   logic [lwmf_pkg::RADIUS_W-1:0] line_radius_ff, line_radius_in;
   logic [lwmf_pkg::RADIUS_W-1:0] csr_radius_ff, csr_radius_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [lwmf_pkg::SAMPLE_W-1:0] rsp_min_ff, rsp_min_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          running;
   logic                          slot_free;
   logic                          accept;
   logic                          line_start;
   logic                          end_of_line;
   logic                          has_result;
   logic                          flush_done;
   logic                          emit;
   logic                          emit_last;
   logic [lwmf_pkg::RADIUS_W-1:0] radius_sat;
   logic [lwmf_pkg::RADIUS_W-1:0] radius_cur;
   logic [lwmf_pkg::POS_W-1:0]    radius_pos;
   logic [lwmf_pkg::POS_W-1:0]    flush_radius;
   logic [lwmf_pkg::POS_W-1:0]    flush_start;
   logic [lwmf_pkg::POS_W-1:0]    flush_len;

   // Handshake: a sample is taken only while the result slot can take its result.
   assign running    = (state_ff == ST_RUN);
   assign slot_free  = !rsp_valid_ff || rsp_bus.ready;
   assign accept     = req_bus.valid && running && slot_free;
   assign req_bus.ready = running && slot_free;

   // The radius is latched with the first sample of each line.
   assign radius_sat = (int'(csr_radius_ff) > lwmf_pkg::MAX_RADIUS) ?
                       lwmf_pkg::RADIUS_W'(lwmf_pkg::MAX_RADIUS) : csr_radius_ff;
   assign line_start = (pos_ff == '0);
   assign radius_cur = line_start ? radius_sat : line_radius_ff;
   assign radius_pos = lwmf_pkg::POS_W'(radius_cur);

   // A line also ends when it reaches the longest line the block counts.
   assign end_of_line = req_bus.last_in_line || (pos_ff == lwmf_pkg::POS_LAST);
   assign has_result  = (pos_ff >= radius_pos);

   // During the flush the window of the target runs from target - r to the line end.
   assign flush_radius = lwmf_pkg::POS_W'(line_radius_ff);
   assign flush_start  = (target_ff >= flush_radius) ? target_ff - flush_radius : '0;
   assign flush_len    = end_ff - flush_start;
   assign flush_done   = (target_ff == end_ff);

   // Control for the row of cells.
   always_comb begin
      chain_ctl.shift      = accept;
      chain_ctl.line_start = line_start;
      chain_ctl.flush      = !running;
      chain_ctl.tap        = running ?
                             lwmf_pkg::TAP_W'({radius_cur, 1'b0}) :
                             flush_len[lwmf_pkg::TAP_W-1:0];
   end

   // Sequencer: one result per ordinary sample at or beyond the radius, a burst of results after the last.
   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      target_in      = target_ff;
      end_in         = end_ff;
      line_radius_in = line_radius_ff;
      emit           = 1'b0;
      emit_last      = 1'b0;
      case (state_ff)
         ST_RUN: begin
            if (accept) begin
               if (line_start) begin
                  line_radius_in = radius_sat;
               end
               if (end_of_line) begin
                  pos_in    = '0;
                  target_in = has_result ? pos_ff - radius_pos : '0;
                  end_in    = pos_ff;
                  state_in  = ST_FLUSH;
               end else begin
                  pos_in = pos_ff + 1'b1;
                  emit   = has_result;
               end
            end
         end
         ST_FLUSH: begin
            if (slot_free) begin
               emit = 1'b1;
               if (flush_done) begin
                  emit_last = 1'b1;
                  state_in  = ST_RUN;
               end else begin
                  target_in = target_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   // Result register parts the two channels.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_min_in   = rsp_min_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_min_in   = tap_value;
         rsp_last_in  = emit_last;
      end
   end

   // Configuration register.
   assign csr_radius_in = csr_write_enable ? csr_write_data : csr_radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_RUN;
         pos_ff         <= '0;
         line_radius_ff <= '0;
         csr_radius_ff  <= lwmf_pkg::DEFAULT_RADIUS;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pos_ff         <= pos_in;
         line_radius_ff <= line_radius_in;
         csr_radius_ff  <= csr_radius_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff   <= target_in;
      end_ff      <= end_in;
      rsp_min_ff  <= rsp_min_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.min_value    = rsp_min_ff;
   assign rsp_bus.last_of_line = rsp_last_ff;

endmodule

@@ rtl/line_window_min_filter.sv @@
// Top level of the line window minimum filter: sequencer plus row of cells.
// Depends on lwmf_pkg, lwmf_if, lwmf_cell, lwmf_chain, lwmf_ctrl and the defines header.
//
// The filter gives, for each sample position of a line, the minimum over the
// samples from radius before to radius after it, clipped at both line ends.
// A row of 2*31+1 cells keeps the running minimum of the last 1, 2, ... 63
// samples; a tap select picks the window length. An ordinary sample is taken
// when valid and ready meet, and its result (when the position is at least the
// radius) appears in the result register in the next cycle. The sample marked
// last, or the 4096th of a line, closes the line: the input then stays blocked
// while the outstanding min(p, r) + 1 results, p being its position, leave one
// per clock from the same tap select unless the output stalls, the final one
// marked. A radius write takes effect with the first sample of the next line.
// Output stalls hold the input back. No clearing pass after reset is needed.
`timescale 1ns / 1ps
`include "line_window_min_filter_defines.svh"

module line_window_min_filter (
   input  logic                          clock,
   input  logic                          reset,
   lwmf_req_if.sink                      req_bus,
   lwmf_rsp_if.source                    rsp_bus,
   input  logic                          csr_write_enable,
   input  logic [lwmf_pkg::RADIUS_W-1:0] csr_write_data
);

   lwmf_pkg::chain_ctrl_type      chain_ctl;
   logic [lwmf_pkg::SAMPLE_W-1:0] tap_value;

   // Sequencer and result register.
   lwmf_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .tap_value        (tap_value),
      .chain_ctl        (chain_ctl)
   );

   // Row of running-minimum cells.
   lwmf_chain u_chain (
      .clock     (clock),
      .ctl       (chain_ctl),
      .sample    (req_bus.sample),
      .tap_value (tap_value)
   );

   // No sample is taken while the results of a closed line are still leaving.
   `LWMF_ASSERT_IMPLIES(a_no_accept_in_flush, clock, reset, chain_ctl.flush,
      !(req_bus.valid && req_bus.ready), "sample accepted during line flush")

   // The tap always names an existing cell.
   `LWMF_ASSERT_ALWAYS(a_tap_in_range, clock, reset,
      chain_ctl.tap < lwmf_pkg::TAP_W'(lwmf_pkg::CHAIN_DEPTH), "tap index beyond row")

   // Leaving the flush means the marked final result of the line was just loaded.
   `LWMF_ASSERT_IMPLIES(a_flush_ends_marked, clock, reset,
      $fell(chain_ctl.flush) && !$past(reset),
      rsp_bus.valid && rsp_bus.last_of_line, "flush ended without final result")

endmodule
